>>> rtl/ths_pkg.sv
// Shared types and constants for the toggle handshake serial sender.
package ths_pkg;

  localparam int THS_BITS_PER_WORD = 8;
  localparam int THS_BYTE_W        = 8;

  // One-hot phase codes.
  typedef enum logic [4:0] {
    PH_START     = 5'b00001,
    PH_WAIT_FALL = 5'b00010,
    PH_IDLE      = 5'b00100,
    PH_SEND      = 5'b01000,
    PH_FAULT     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic ack_level;
    logic byte_offered;
    logic [THS_BYTE_W-1:0] byte_value;
  } ths_req_t;

  typedef struct packed {
    logic data_level;
    logic ready_level;
    logic byte_taken;
    logic can_accept;
    logic fault;
  } ths_rsp_t;

endpackage

>>> rtl/ths_in_if.sv
// Request channel interface: ack sample and optional byte.
interface ths_in_if
  import ths_pkg::*;
();
  logic valid;
  logic ready;
  logic ack_level;
  logic byte_offered;
  logic [THS_BYTE_W-1:0] byte_value;

  modport source (output valid, output ack_level, output byte_offered,
                  output byte_value, input ready);
  modport sink (input valid, input ack_level, input byte_offered,
                input byte_value, output ready);
endinterface

>>> rtl/ths_out_if.sv
// Result channel interface: line levels and status after each request.
interface ths_out_if;
  logic valid;
  logic ready;
  logic data_level;
  logic ready_level;
  logic byte_taken;
  logic can_accept;
  logic fault;

  modport source (output valid, output data_level, output ready_level,
                  output byte_taken, output can_accept, output fault,
                  input ready);
  modport sink (input valid, input data_level, input ready_level,
                input byte_taken, input can_accept, input fault,
                output ready);
endinterface

>>> rtl/ths_core.sv
// Handshake sequencer: phase, shift store, bit counter and line levels.
module ths_core
  import ths_pkg::*;
#(
  parameter int BITS_PER_WORD = THS_BITS_PER_WORD
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  ths_req_t req,
  output ths_rsp_t rsp
);

  localparam int IDX_W = (BITS_PER_WORD > 1) ? $clog2(BITS_PER_WORD) : 1;

  phase_t                phase_r, phase_nxt;
  logic [THS_BYTE_W-1:0] shift_r, shift_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  rdy_r, rdy_nxt;
  logic                  data_r, data_nxt;
  logic                  taken;
  logic [IDX_W:0]        idx_inc;

  // Bits past the eighth go out as zero.
  function automatic logic pick_bit(input logic [THS_BYTE_W-1:0] word,
                                    input logic [IDX_W-1:0] idx);
    logic [IDX_W+2:0] idx_w;
    idx_w = (IDX_W+3)'(idx);
    if (idx_w < (IDX_W+3)'(THS_BYTE_W)) begin
      return word[idx_w[2:0]];
    end
    return 1'b0;
  endfunction

  assign idx_inc = {1'b0, idx_r} + (IDX_W+1)'(1);

  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    idx_nxt   = idx_r;
    rdy_nxt   = rdy_r;
    data_nxt  = data_r;
    taken     = 1'b0;
    case (phase_r)
      PH_WAIT_FALL: begin
        if (!req.ack_level) phase_nxt = PH_IDLE;
      end
      PH_IDLE: begin
        if (req.byte_offered) begin
          taken     = 1'b1;
          shift_nxt = req.byte_value;
          idx_nxt   = '0;
          data_nxt  = req.byte_value[0];
          rdy_nxt   = ~rdy_r;
          phase_nxt = PH_SEND;
        end
      end
      PH_SEND: begin
        // receiver echoes the level ready had before the toggle
        if (req.ack_level == ~rdy_r) begin
          if (idx_inc == (IDX_W+1)'(BITS_PER_WORD)) begin
            idx_nxt   = '0;
            phase_nxt = PH_IDLE;
          end else begin
            idx_nxt  = idx_inc[IDX_W-1:0];
            data_nxt = pick_bit(shift_r, idx_inc[IDX_W-1:0]);
            rdy_nxt  = ~rdy_r;
          end
        end
      end
      PH_FAULT: begin
      end
      default: begin
        phase_nxt = req.ack_level ? PH_WAIT_FALL : PH_FAULT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      shift_r <= '0;
      idx_r   <= '0;
      rdy_r   <= 1'b1;
      data_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      idx_r   <= idx_nxt;
      rdy_r   <= rdy_nxt;
      data_r  <= data_nxt;
    end
  end

  always_comb begin
    rsp.data_level  = data_nxt;
    rsp.ready_level = rdy_nxt;
    rsp.byte_taken  = taken;
    rsp.can_accept  = (phase_nxt == PH_IDLE);
    rsp.fault       = (phase_nxt == PH_FAULT);
  end

endmodule

>>> rtl/ths_out_reg.sv
// Result register; frees the request side whenever the slot empties.
module ths_out_reg
  import ths_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  ths_rsp_t load_data,
  input  logic     take,
  output logic     space,
  output logic     valid,
  output ths_rsp_t data
);

  logic     valid_r;
  ths_rsp_t data_r;

  assign space = !valid_r || take;
  assign valid = valid_r;
  assign data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= load_data;
  end

endmodule

>>> rtl/toggle_handshake_serial_sender.sv
// The result of an accepted request is held in the output register from the next cycle on.
// Throughput: one request per cycle; the only limit is the result register,
// which takes a new result in the cycle the old one is drained.
// Reset (synchronous, active low): phase start check, ready line high, data line low,
// result register empty.
module toggle_handshake_serial_sender
  import ths_pkg::*;
#(
  parameter int BITS_PER_WORD = THS_BITS_PER_WORD
) (
  input  logic         clk,
  input  logic         rst_n,
  ths_in_if.sink       in_ch,
  ths_out_if.source    out_ch
);

  ths_req_t req;
  ths_rsp_t rsp;
  ths_rsp_t out_data;
  logic     space;
  logic     step;
  logic     take;

  assign req.ack_level    = in_ch.ack_level;
  assign req.byte_offered = in_ch.byte_offered;
  assign req.byte_value   = in_ch.byte_value;

  assign in_ch.ready = space;
  assign step        = in_ch.valid && space;
  assign take        = out_ch.valid && out_ch.ready;

  ths_core #(
    .BITS_PER_WORD(BITS_PER_WORD)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .step (step),
    .req  (req),
    .rsp  (rsp)
  );

  ths_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step),
    .load_data(rsp),
    .take     (take),
    .space    (space),
    .valid    (out_ch.valid),
    .data     (out_data)
  );

  assign out_ch.data_level  = out_data.data_level;
  assign out_ch.ready_level = out_data.ready_level;
  assign out_ch.byte_taken  = out_data.byte_taken;
  assign out_ch.can_accept  = out_data.can_accept;
  assign out_ch.fault       = out_data.fault;

endmodule

>>> rtl/ths_checker.sv
// Port-level checks for the toggle handshake serial sender.
module ths_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic byte_taken,
  input logic can_accept,
  input logic fault
);

  // A stalled result blocks new requests.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request side ready while result stalled");

  // Every accepted request yields a result next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after accepted request");

  a_taken_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && byte_taken |-> !can_accept && !fault)
    else $error("byte taken while idle or faulted");

  a_idle_fault_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(can_accept && fault))
    else $error("idle and fault at once");

endmodule

bind toggle_handshake_serial_sender ths_checker u_ths_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .byte_taken(out_ch.byte_taken),
  .can_accept(out_ch.can_accept),
  .fault     (out_ch.fault)
);

>>> bench/tb.sv
// Self-checking bench for the toggle handshake serial sender: random receiver, gaps, stalls.
`timescale 1ns / 1ps

module tb;
  import ths_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_REQS = 1650;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  shift_q;
    logic [4:0]  bit_idx;
    logic        ready_q;
    logic        data_q;
  } sender_state_t;

  logic clk;
  logic rst_n;

  ths_in_if  in_ch();
  ths_out_if out_ch();

  toggle_handshake_serial_sender u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ths_req_t      stim_q[$];
  ths_rsp_t      line_expect_q[$];
  sender_state_t gen_state;   // shadow used to shape the receiver's acks
  sender_state_t line_model;  // predicts what the block reports
  ths_req_t      cur_req;
  int            in_gap;
  int            out_stall;
  int            accepted;
  int            total_reqs;
  int            errors;
  int            cycles;

  always #6 clk = ~clk;

  function automatic sender_state_t sender_reset_state();
    sender_state_t s;
    s.phase   = PH_START;
    s.shift_q = '0;
    s.bit_idx = '0;
    s.ready_q = 1'b1;
    s.data_q  = 1'b0;
    return s;
  endfunction

  function automatic void put_bit(inout sender_state_t s);
    s.data_q  = (s.bit_idx < THS_BYTE_W) ? s.shift_q[s.bit_idx[2:0]] : 1'b0;
    s.ready_q = ~s.ready_q;
  endfunction

  // Advances the sender by one request and returns the line levels after it.
  function automatic ths_rsp_t sender_step(inout sender_state_t s, input ths_req_t r);
    ths_rsp_t o;
    logic     taken;
    taken = 1'b0;
    case (s.phase)
      PH_WAIT_FALL: if (!r.ack_level) s.phase = PH_IDLE;
      PH_IDLE: begin
        if (r.byte_offered) begin
          taken     = 1'b1;
          s.shift_q = r.byte_value;
          s.bit_idx = '0;
          put_bit(s);
          s.phase   = PH_SEND;
        end
      end
      PH_SEND: begin
        // receiver acks by echoing the ready level from before the toggle
        if (r.ack_level == ~s.ready_q) begin
          s.bit_idx = s.bit_idx + 1'b1;
          if (s.bit_idx >= THS_BITS_PER_WORD) begin
            s.bit_idx = '0;
            s.phase   = PH_IDLE;
          end else begin
            put_bit(s);
          end
        end
      end
      PH_FAULT: ;
      default: s.phase = r.ack_level ? PH_WAIT_FALL : PH_FAULT;
    endcase
    o.data_level  = s.data_q;
    o.ready_level = s.ready_q;
    o.byte_taken  = taken;
    o.can_accept  = (s.phase == PH_IDLE);
    o.fault       = (s.phase == PH_FAULT);
    return o;
  endfunction

  function automatic int idle_len();
    int r;
    if ((accepted / 200) % 4 == 1) return 0;  // stretch with no idling
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic push_request(input logic ack, input logic offered, input logic [7:0] value);
    ths_req_t r;
    r.ack_level    = ack;
    r.byte_offered = offered;
    r.byte_value   = value;
    void'(sender_step(gen_state, r));
    stim_q.push_back(r);
  endtask

  // Virtual receiver: while a bit is in flight, acks with the given chance per request.
  task automatic add_request(input int ack_pct, input int offer_pct, input bit noisy);
    logic ack;
    if (gen_state.phase == PH_SEND)
      ack = ($urandom_range(0, 99) < ack_pct) ? ~gen_state.ready_q : gen_state.ready_q;
    else
      ack = 1'($urandom_range(0, 1));
    if (noisy && $urandom_range(0, 99) < 5) ack = 1'($urandom_range(0, 1));
    push_request(ack, $urandom_range(0, 99) < offer_pct, 8'($urandom_range(0, 255)));
  endtask

  task automatic check_level(input string name, input logic exp_v, input logic act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap      <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        line_expect_q.push_back(sender_step(line_model, cur_req));
        accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap      <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          cur_req = stim_q.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.ack_level    <= cur_req.ack_level;
          in_ch.byte_offered <= cur_req.byte_offered;
          in_ch.byte_value   <= cur_req.byte_value;
          in_gap             <= idle_len();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    ths_rsp_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (line_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual data %0b ready %0b",
                   $time, out_ch.data_level, out_ch.ready_level);
          errors++;
        end else begin
          exp_r = line_expect_q.pop_front();
          check_level("data_level", exp_r.data_level, out_ch.data_level);
          check_level("ready_level", exp_r.ready_level, out_ch.ready_level);
          check_level("byte_taken", exp_r.byte_taken, out_ch.byte_taken);
          check_level("can_accept", exp_r.can_accept, out_ch.can_accept);
          check_level("fault", exp_r.fault, out_ch.fault);
        end
      end
      if (out_stall > 0) begin
        out_stall    <= out_stall - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_stall    <= idle_len();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.ack_level    = 1'b0;
    in_ch.byte_offered = 1'b0;
    in_ch.byte_value   = '0;
    out_ch.ready       = 1'b0;
    accepted           = 0;
    errors             = 0;
    cycles             = 0;
    gen_state          = sender_reset_state();
    line_model         = sender_reset_state();

    // start check passes, offers during wait-for-fall are ignored
    push_request(1'b1, 1'b0, 8'h00);
    push_request(1'b1, 1'b1, 8'hFF);
    push_request(1'b1, 1'b0, 8'h00);
    push_request(1'b0, 1'b1, 8'hAA);
    // all-ones byte taken with ack still high; prompt acks, offers while busy
    push_request(1'b1, 1'b1, 8'hFF);
    repeat (8) add_request(100, 100, 1'b0);
    push_request(1'b0, 1'b1, 8'h00);
    repeat (8) add_request(100, 100, 1'b0);

    for (int i = 0; i < RANDOM_REQS; i++)
      add_request((i / 300) % 2 ? 85 : 30, 50, 1'b1);

    total_reqs = stim_q.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // every request accepted and every result checked
    while (accepted < total_reqs || line_expect_q.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);

    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
